[rtl/chca_pkg.sv]
// Shared types and constants for the canonical Huffman code assignment block.
// Used by chca_ctrl, chca_datapath and canonical_huffman_code_assign.
`default_nettype none

package chca_pkg;

   localparam int LEN_W   = 5;
   localparam int CODE_W  = 16;
   localparam int TALLY_W = 10;

   typedef enum logic {
      CMD_COUNT  = 1'b0,
      CMD_ASSIGN = 1'b1
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_BUILD
   } state_type;

   typedef struct packed {
      logic accept;
      logic build_step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_build;
      logic build_last;
   } ctrl_stat_type;

endpackage

`default_nettype wire

[rtl/canonical_huffman_code_assign.sv]
// Top level of the canonical Huffman code assignment block.
// Depends on chca_pkg, chca_ctrl and chca_datapath.
`default_nettype none

// Usage:
// An item (req_cmd, req_code_length, req_last) is taken at a rising edge where
// start is high and busy is low. Count items (req_cmd = 0) tally code lengths;
// only the final count item gives a result. Assign items (req_cmd = 1) each give
// one result carrying the symbol's canonical code.
// Each result sits on the rsp_ ports for one cycle with rsp_strobe high; the
// receiver must take it then, as there is no back-pressure.
// Timing: the result of a count or assign item appears the cycle after
// acceptance. The final count item starts the first-code build, one table entry
// per cycle for lengths 1 .. LENGTH_LIMIT-1, while busy stays high, and the
// status result follows the last entry. When a length reached LENGTH_LIMIT, no
// build runs and the error status comes the cycle after acceptance.
// Reset clears the tally, the longest length, the error flag and the controller.
// The code table holds garbage until the first build writes it.
module canonical_huffman_code_assign #(
   parameter int LENGTH_LIMIT = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic                        req_cmd,
   input  wire logic [chca_pkg::LEN_W-1:0]  req_code_length,
   input  wire logic                        req_last,
   output logic                             rsp_strobe,
   output logic [chca_pkg::CODE_W-1:0]      rsp_code_value,
   output logic [chca_pkg::LEN_W-1:0]       rsp_length_echo,
   output logic                             rsp_has_code,
   output logic                             rsp_error,
   output logic                             rsp_last_out
);
   import chca_pkg::*;

   ctrl_cmd_type  ctrl_cmd;
   ctrl_stat_type ctrl_stat;

   chca_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (ctrl_stat),
      .cmd   (ctrl_cmd)
   );

   chca_datapath #(
      .LENGTH_LIMIT (LENGTH_LIMIT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (ctrl_cmd),
      .stat            (ctrl_stat),
      .req_cmd         (req_cmd),
      .req_code_length (req_code_length),
      .req_last        (req_last),
      .rsp_strobe      (rsp_strobe),
      .rsp_code_value  (rsp_code_value),
      .rsp_length_echo (rsp_length_echo),
      .rsp_has_code    (rsp_has_code),
      .rsp_error       (rsp_error),
      .rsp_last_out    (rsp_last_out)
   );

endmodule

`default_nettype wire

[rtl/chca_ctrl.sv]
// Controller state machine: accepts items and sequences the first-code table build.
// Depends on chca_pkg.
`default_nettype none

module chca_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  chca_pkg::ctrl_stat_type     stat,
   output chca_pkg::ctrl_cmd_type      cmd
);
   import chca_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && stat.need_build) begin
               state_in = ST_BUILD;
            end
         end
         ST_BUILD: begin
            if (stat.build_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy           = (state_ff != ST_IDLE);
      cmd.accept     = start && (state_ff == ST_IDLE);
      cmd.build_step = (state_ff == ST_BUILD);
   end

`ifndef NO_ASSERTIONS
   a_enter_build: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && stat.need_build) |=> (state_ff == ST_BUILD))
      else $error("build did not start after the final count item");

   a_leave_build: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BUILD && stat.build_last) |=> (state_ff == ST_IDLE))
      else $error("build did not end after the last table entry");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !start) |=> (state_ff == ST_IDLE))
      else $error("controller left idle without an item");
`endif

endmodule

`default_nettype wire

[rtl/chca_datapath.sv]
// Datapath: length tally, next-code table, build accumulator and result registers.
// Depends on chca_pkg; driven by chca_ctrl through command and status structs.
`default_nettype none

module chca_datapath #(
   parameter int LENGTH_LIMIT = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  chca_pkg::ctrl_cmd_type           cmd,
   output chca_pkg::ctrl_stat_type          stat,
   input  wire logic                        req_cmd,
   input  wire logic [chca_pkg::LEN_W-1:0]  req_code_length,
   input  wire logic                        req_last,
   output logic                             rsp_strobe,
   output logic [chca_pkg::CODE_W-1:0]      rsp_code_value,
   output logic [chca_pkg::LEN_W-1:0]       rsp_length_echo,
   output logic                             rsp_has_code,
   output logic                             rsp_error,
   output logic                             rsp_last_out
);
   import chca_pkg::*;

   localparam int IDX_W = (LENGTH_LIMIT > 1) ? $clog2(LENGTH_LIMIT) : 1;
   localparam logic [LEN_W:0] LIMIT_EXT = (LEN_W + 1)'(LENGTH_LIMIT);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LENGTH_LIMIT - 1);
   localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(1);

   logic [TALLY_W-1:0] tally_ff [LENGTH_LIMIT];
   logic [CODE_W-1:0]  code_tab_ff [LENGTH_LIMIT];
   logic [LEN_W-1:0]   longest_ff;
   logic               error_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [CODE_W-1:0]  acc_ff;

   logic               rsp_strobe_ff;
   logic [CODE_W-1:0]  rsp_code_ff;
   logic [LEN_W-1:0]   rsp_length_ff;
   logic               rsp_has_ff;
   logic               rsp_error_ff;
   logic               rsp_last_ff;

   logic               is_count;
   logic               len_in_range;
   logic [IDX_W-1:0]   len_idx;
   logic [IDX_W-1:0]   tally_addr;
   logic [TALLY_W-1:0] tally_rd;
   logic [TALLY_W-1:0] prev_tally;
   logic [CODE_W-1:0]  code_tab_rd;
   logic [LEN_W-1:0]   longest_in;
   logic               hit;
   logic [CODE_W-1:0]  sum_code;
   logic [CODE_W-1:0]  build_code;

   always_comb begin
      is_count     = (req_cmd == CMD_COUNT);
      len_in_range = ({1'b0, req_code_length} < LIMIT_EXT);
      len_idx      = req_code_length[IDX_W-1:0];
      // The tally has one read port, shared by counting and the table build.
      tally_addr   = cmd.build_step ? (idx_ff - IDX_FIRST) : len_idx;
      tally_rd     = tally_ff[tally_addr];
      prev_tally   = (idx_ff == IDX_FIRST) ? '0 : tally_rd;
      code_tab_rd  = code_tab_ff[len_idx];
      longest_in   = (req_code_length > longest_ff) ? req_code_length : longest_ff;
      hit          = !error_ff && (req_code_length != '0) && len_in_range;
      sum_code     = acc_ff + CODE_W'(prev_tally);
      build_code   = {sum_code[CODE_W-2:0], 1'b0};

      stat.need_build = is_count && req_last && ({1'b0, longest_in} < LIMIT_EXT);
      stat.build_last = (idx_ff == IDX_LAST);
   end

   // Tally, longest length and error flag; the final assign item clears them.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LENGTH_LIMIT; i++) begin
            tally_ff[i] <= '0;
         end
         longest_ff <= '0;
         error_ff   <= 1'b0;
      end else if (cmd.accept) begin
         if (is_count) begin
            if (len_in_range) begin
               tally_ff[len_idx] <= tally_rd + TALLY_W'(1);
            end
            longest_ff <= longest_in;
            if (req_last && !stat.need_build) begin
               error_ff <= 1'b1;
            end
         end else if (req_last) begin
            for (int i = 0; i < LENGTH_LIMIT; i++) begin
               tally_ff[i] <= '0;
            end
            longest_ff <= '0;
            error_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.build_step) begin
         code_tab_ff[idx_ff] <= build_code;
      end else if (cmd.accept && !is_count && hit) begin
         code_tab_ff[len_idx] <= code_tab_rd + CODE_W'(1);
      end
   end

   // Build walks lengths 1 .. LENGTH_LIMIT-1, one entry per cycle.
   always_ff @(posedge clock) begin
      if (cmd.accept && stat.need_build) begin
         idx_ff <= IDX_FIRST;
         acc_ff <= '0;
      end else if (cmd.build_step) begin
         idx_ff <= idx_ff + IDX_FIRST;
         acc_ff <= build_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (cmd.accept && (!is_count || (req_last && !stat.need_build)))
                          || (cmd.build_step && stat.build_last);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rsp_length_ff <= req_code_length;
         rsp_last_ff   <= req_last;
         if (is_count) begin
            rsp_code_ff  <= '0;
            rsp_has_ff   <= 1'b0;
            rsp_error_ff <= 1'b1;
         end else begin
            rsp_code_ff  <= hit ? code_tab_rd : '0;
            rsp_has_ff   <= hit;
            rsp_error_ff <= error_ff;
         end
      end else if (cmd.build_step) begin
         rsp_code_ff  <= '0;
         rsp_has_ff   <= 1'b0;
         rsp_error_ff <= error_ff;
         rsp_last_ff  <= 1'b1;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_code_value  = rsp_code_ff;
   assign rsp_length_echo = rsp_length_ff;
   assign rsp_has_code    = rsp_has_ff;
   assign rsp_error       = rsp_error_ff;
   assign rsp_last_out    = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_code_no_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_has_code) |-> !rsp_error)
      else $error("code issued while the table is in error");

   a_code_nonzero_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_has_code) |-> (rsp_length_echo != '0))
      else $error("code issued for an unused symbol");

   a_pass_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && !is_count && req_last) |=> (longest_ff == '0 && !error_ff))
      else $error("final assign item did not clear the pass state");
`endif

endmodule

`default_nettype wire
